### rtl/ordq_pkg.sv
package ordq_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CntW  = 5;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_CLEAR      = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERWRITE = 2'd1,
    STATUS_EMPTY     = 2'd2
  } status_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic rd_front;
    logic rd_back;
    logic cap_pop;
    logic cap_front;
    logic load_out;
  } ordq_cmd_t;

endpackage

### rtl/ordq_ram.sv
module ordq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ordq_ctrl.sv
module ordq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ordq_pkg::ordq_cmd_t cmd_o
);

  import ordq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_FRONT,
    ST_RD_BACK,
    ST_LOAD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC:     state_q <= ST_RD_FRONT;
        ST_RD_FRONT: state_q <= ST_RD_BACK;
        ST_RD_BACK:  state_q <= ST_LOAD;
        ST_LOAD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.exec      = (state_q == ST_EXEC);
    cmd_o.rd_front  = (state_q == ST_RD_FRONT);
    cmd_o.cap_pop   = (state_q == ST_RD_FRONT);
    cmd_o.rd_back   = (state_q == ST_RD_BACK);
    cmd_o.cap_front = (state_q == ST_RD_BACK);
    cmd_o.load_out  = (state_q == ST_LOAD) && out_free;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/ordq_dpath.sv
module ordq_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ordq_pkg::ordq_cmd_t        cmd_i,
  input  logic [2:0]                 kind_i,
  input  logic signed [31:0]         push_value_i,
  input  logic                       cfg_we_i,
  input  logic [4:0]                 cfg_wdata_i,
  output logic [1:0]                 status_o,
  output logic signed [31:0]         popped_value_o,
  output logic signed [31:0]         front_value_o,
  output logic signed [31:0]         back_value_o,
  output logic [4:0]                 count_o
);

  import ordq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned XW = ((IW > CntW) ? IW : CntW) + 1;

  logic [CntW-1:0]  cap_q;
  logic [CntW-1:0]  cap_eff;
  logic [IW-1:0]    front_q, front_d;
  logic [IW-1:0]    back_q, back_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [2:0]       kind_q;
  logic [WordW-1:0] value_q;
  logic [1:0]       status_q, status_d;
  logic             pop_hit_q, pop_hit_d;
  logic [WordW-1:0] popped_q, frontv_q;

  logic [1:0]       status_out_q;
  logic [WordW-1:0] popped_out_q, front_out_q, back_out_q;
  logic [CntW-1:0]  count_out_q;

  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [WordW-1:0] wr_data;
  logic             pop_re;
  logic [IW-1:0]    pop_addr;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic [WordW-1:0] rd_data;
  logic             full;

  function automatic logic [IW-1:0] idx_up(logic [IW-1:0] i, logic [CntW-1:0] cap);
    logic [XW-1:0] n;
    n = XW'(i) + XW'(1);
    return (n > XW'(cap) - XW'(1)) ? '0 : n[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] idx_down(logic [IW-1:0] i, logic [CntW-1:0] cap);
    logic [XW-1:0] m;
    m = XW'(cap) - XW'(1);
    return (i == '0) ? m[IW-1:0] : i - IW'(1);
  endfunction

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CntW'(1);
    end else if (int'(cap_q) > int'(DEPTH)) begin
      cap_eff = CntW'(DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign full = (count_q >= cap_eff);

  always_comb begin
    front_d   = front_q;
    back_d    = back_q;
    count_d   = count_q;
    status_d  = STATUS_OK;
    pop_hit_d = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = value_q;
    pop_re    = 1'b0;
    pop_addr  = front_q;
    case (kind_e'(kind_q))
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        wr_en = 1'b1;
        if (count_q == '0) begin
          front_d = '0;
          back_d  = '0;
          count_d = CntW'(1);
          wr_addr = '0;
        end else if (kind_e'(kind_q) == KIND_PUSH_FRONT) begin
          if (full) begin
            wr_addr  = back_q;
            front_d  = back_q;
            back_d   = idx_up(back_q, cap_eff);
            status_d = STATUS_OVERWRITE;
          end else begin
            front_d = idx_up(front_q, cap_eff);
            wr_addr = front_d;
            count_d = count_q + CntW'(1);
          end
        end else begin
          if (full) begin
            wr_addr  = front_q;
            back_d   = front_q;
            front_d  = idx_down(front_q, cap_eff);
            status_d = STATUS_OVERWRITE;
          end else begin
            back_d  = idx_down(back_q, cap_eff);
            wr_addr = back_d;
            count_d = count_q + CntW'(1);
          end
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (count_q == '0) begin
          status_d = STATUS_EMPTY;
        end else if (kind_e'(kind_q) == KIND_POP_FRONT) begin
          pop_re    = 1'b1;
          pop_hit_d = 1'b1;
          pop_addr  = front_q;
          front_d   = idx_down(front_q, cap_eff);
          count_d   = count_q - CntW'(1);
        end else begin
          pop_re    = 1'b1;
          pop_hit_d = 1'b1;
          pop_addr  = back_q;
          back_d    = idx_up(back_q, cap_eff);
          count_d   = count_q - CntW'(1);
        end
      end
      KIND_CLEAR: begin
        front_d = '0;
        back_d  = '0;
        count_d = '0;
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rd_en   = (cmd_i.exec && pop_re) || cmd_i.rd_front || cmd_i.rd_back;
    rd_addr = cmd_i.exec ? pop_addr : (cmd_i.rd_front ? front_q : back_q);
  end

  ordq_ram #(
    .WIDTH(WordW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exec && wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CntW'(16);
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else begin
      if (cfg_we_i && count_q == '0) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        front_q <= front_d;
        back_q  <= back_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= kind_i;
      value_q <= push_value_i;
    end
    if (cmd_i.exec) begin
      status_q  <= status_d;
      pop_hit_q <= pop_hit_d;
    end
    if (cmd_i.cap_pop) begin
      popped_q <= pop_hit_q ? rd_data : '0;
    end
    if (cmd_i.cap_front) begin
      frontv_q <= (count_q != '0) ? rd_data : '0;
    end
    if (cmd_i.load_out) begin
      status_out_q <= status_q;
      popped_out_q <= popped_q;
      front_out_q  <= frontv_q;
      back_out_q   <= (count_q != '0) ? rd_data : '0;
      count_out_q  <= count_q;
    end
  end

  assign status_o       = status_out_q;
  assign popped_value_o = popped_out_q;
  assign front_value_o  = front_out_q;
  assign back_value_o   = back_out_q;
  assign count_o        = count_out_q;

endmodule

### rtl/overwriting_ring_deque.sv
// Double-ended ring buffer of signed 32-bit words with overwrite on full.
// Input channel: in_valid_i / in_stall_o carry one request (kind_i,
// push_value_i); it is taken at an edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry one result per request
// (status, popped value, front and back values after the step, count).
// Configuration: cfg_we_i writes capacity_in_use from cfg_wdata_i; the
// write only takes effect while the buffer is empty.
// Sequencing: the block works on one request at a time and takes no new
// request until the current one is done: a request first gets its index
// update and slot write, then the single read port of the slot RAM fetches
// the popped word, the new front and the new back on successive cycles,
// and the result is then loaded into the output register.
// The output register holds a finished result while the receiver stalls;
// the next request is still taken and completes up to its final load, then
// waits there until the output register is free.
// Reset: asynchronous, active low; empties the buffer, sets capacity to 16
// and drops any result in flight. Slot contents are not cleared.
module overwriting_ring_deque #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] popped_value_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic [4:0]         count_o,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i
);

  import ordq_pkg::*;

  ordq_cmd_t cmd;

  ordq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  ordq_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (kind_i),
    .push_value_i  (push_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .status_o      (status_o),
    .popped_value_o(popped_value_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .count_o       (count_o)
  );

endmodule
